### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers shared by the RTL. Defining NO_ASSERTIONS removes them.

`ifndef NO_ASSERTIONS

// The condition must hold at every clock edge outside reset.
`define SWM_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// When the trigger holds, the condition must hold in the next cycle.
`define SWM_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

`else

`define SWM_ASSERT(label, clk, rst, cond)
`define SWM_ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

### design/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'h0;

  // Window length register.
  localparam int WL_WIDTH = 7;
  localparam int WL_RESET = 3;

  // Control broadcast to every cell.
  typedef struct packed {
    logic step;   // a sample is accepted this cycle
    logic full;   // the window holds its full length
    logic clear;  // empty the sorted window
  } swm_ctl_t;

  // What a sorted cell tells the cell below it about its own entry.
  typedef struct packed {
    logic vld;   // entry holds a sample
    logic lt_v;  // entry is below the incoming sample
    logic eq_r;  // entry equals the sample that leaves
  } swm_flags_t;

  // What a sorted cell tells the cell above it about its entry once the
  // leaving sample has been taken out.
  typedef struct packed {
    logic vld;
    logic lt_v;
  } swm_pass_t;

endpackage

`default_nettype wire

### design/swm_arr_cell.sv
`default_nettype none

// One entry of the arrival-order line. Once the window is full, every entry
// takes the one above it, and the entry at the window's end takes the new
// sample, so the oldest sample always sits in entry zero.
module swm_arr_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32,
  parameter int IDX_W = 6,
  parameter int POS = 0
) (
  input  logic                           clk,
  input  swm_ctl_t                       ctl,
  input  logic        [IDX_W-1:0]        fill,
  input  logic        [IDX_W-1:0]        k_last,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] up_value,
  output logic signed [SAMPLE_WIDTH-1:0] value
);

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (ctl.full) begin
        if (k_last == IDX_W'(POS)) begin
          value <= sample;
        end else begin
          value <= up_value;
        end
      end else if (fill == IDX_W'(POS)) begin
        value <= sample;
      end
    end
  end

endmodule

`default_nettype wire

### design/swm_sort_cell.sv
`default_nettype none

// One entry of the sorted window. The cell first works out which entry sits
// at its place once the leaving sample is gone, then takes that entry, the
// new sample, or the entry handed up from below.
module swm_sort_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swm_ctl_t                       ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] oldest,
  input  swm_flags_t                     up_flags,
  input  logic signed [SAMPLE_WIDTH-1:0] up_value,
  input  swm_pass_t                      low_pass,
  input  logic signed [SAMPLE_WIDTH-1:0] low_value,
  output swm_flags_t                     flags,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output swm_pass_t                      pass,
  output logic signed [SAMPLE_WIDTH-1:0] pass_value
);

  logic                           vld;
  logic                           vld_next;
  logic signed [SAMPLE_WIDTH-1:0] value_next;
  logic                           below;

  always_comb begin
    flags.vld  = vld;
    flags.lt_v = vld && (value < sample);
    flags.eq_r = vld && (value == oldest);

    // Of equal copies of the leaving sample, the topmost one is removed.
    below = vld && (!ctl.full || (value < oldest) || (flags.eq_r && up_flags.eq_r));

    pass.vld   = below ? vld : up_flags.vld;
    pass.lt_v  = below ? flags.lt_v : up_flags.lt_v;
    pass_value = below ? value : up_value;

    if (pass.lt_v) begin
      vld_next   = pass.vld;
      value_next = pass_value;
    end else if (low_pass.lt_v) begin
      vld_next   = 1'b1;
      value_next = sample;
    end else begin
      vld_next   = low_pass.vld;
      value_next = low_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.clear) begin
      vld <= 1'b0;
    end else if (ctl.step) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

### design/sliding_window_median_unit.sv
// Channel   Direction  Signals                                  Beat
// sample    in         sample_valid, sample_ready, sample       one signed sample
// median    out        median_valid, median_ready, median       lower median of window
// config    in/out     psel, penable, pwrite, paddr, pwdata,    window_length at 0x0
//                      prdata, pready
//
// One sample beat is taken per cycle while the output keeps up. Each sample
// accepted into a full window, or that fills it, yields a median beat.
// Accepting a sample updates the row of sorted cells, each of which works
// against the leaving and the new sample; the output register is then loaded from the row.
// Reset is synchronous and empties the window at once, with no clearing pass.
// A median beat held by a stalled output holds off the next sample only if a
// second result is ready behind it.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_median_unit
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           median_valid,
  input  logic                           median_ready,
  output logic signed [SAMPLE_WIDTH-1:0] median,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic        [APB_ADDR_W-1:0]   paddr,
  input  logic        [APB_DATA_W-1:0]   pwdata,
  output logic        [APB_DATA_W-1:0]   prdata,
  output logic                           pready
);

  // Index width for one window entry, and a width that holds both the
  // register value and the largest window length.
  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int TW = (IW + 1 > WL_WIDTH) ? IW + 1 : WL_WIDTH;
  localparam int RST_K = (WL_RESET > WINDOW_MAX) ? WINDOW_MAX : WL_RESET;
  localparam logic [IW-1:0] RST_K_LAST = IW'(RST_K - 1);
  localparam logic [IW-1:0] RST_MID = IW'((RST_K + 1) / 2 - 1);

  // Configuration state. The effective length is kept as its last index, and
  // the median position as the index of the ((k+1)/2)-th smallest entry.
  logic [WL_WIDTH-1:0] window_length;
  logic [IW-1:0]       k_last;
  logic [IW-1:0]       mid;
  logic [TW-1:0]       wl_ext;
  logic [TW-1:0]       k_new;
  logic                cfg_write;

  // Window fill and handshake state.
  logic [IW-1:0] fill;
  logic          full;
  logic          pend;
  logic          pend_next;
  logic          median_valid_next;
  logic          load;
  logic          accept;
  logic          produces;

  swm_ctl_t ctl;

  // Arrival-order line and sorted row.
  logic signed [SAMPLE_WIDTH-1:0] arr_val    [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] arr_up     [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] sort_val   [WINDOW_MAX];
  swm_flags_t                     sort_flags [WINDOW_MAX];
  swm_pass_t                      sort_pass  [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] sort_pval  [WINDOW_MAX];
  swm_flags_t                     up_flags   [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] up_val     [WINDOW_MAX];
  swm_pass_t                      low_pass   [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] low_val    [WINDOW_MAX];

  logic [WINDOW_MAX-1:0] vld_vec;
  logic                  order_ok;

  // ---------------------------------------------------------------------
  // Configuration port. A zero length acts as one, and lengths beyond the
  // row saturate to its size. A write to window_length empties the window.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == ADDR_WINDOW_LENGTH);

  always_comb begin
    wl_ext = TW'(pwdata[WL_WIDTH-1:0]);
    if (wl_ext == '0) begin
      k_new = TW'(1);
    end else if (wl_ext > TW'(WINDOW_MAX)) begin
      k_new = TW'(WINDOW_MAX);
    end else begin
      k_new = wl_ext;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_WINDOW_LENGTH) begin
      prdata = {{(APB_DATA_W - WL_WIDTH){1'b0}}, window_length};
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. A result is marked pending in the cycle its sample enters
  // the row, and is copied from the row into the output register once that
  // register is free. That copy reads the row before the following sample
  // changes it, so a new sample may enter in the same cycle.
  // ---------------------------------------------------------------------
  assign load         = pend && (!median_valid || median_ready);
  assign sample_ready = !pend || load;
  assign accept       = sample_valid && sample_ready;
  assign produces     = full || (fill == k_last);

  always_comb begin
    pend_next = pend;
    if (accept) begin
      pend_next = produces;
    end else if (load) begin
      pend_next = 1'b0;
    end

    median_valid_next = median_valid;
    if (load) begin
      median_valid_next = 1'b1;
    end else if (median_ready) begin
      median_valid_next = 1'b0;
    end
  end

  always_comb begin
    ctl.step  = accept;
    ctl.full  = full;
    ctl.clear = cfg_write;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_WIDTH'(WL_RESET);
      k_last        <= RST_K_LAST;
      mid           <= RST_MID;
      fill          <= '0;
      full          <= 1'b0;
      pend          <= 1'b0;
      median_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        window_length <= pwdata[WL_WIDTH-1:0];
        k_last        <= IW'(k_new - TW'(1));
        mid           <= IW'(((k_new + TW'(1)) >> 1) - TW'(1));
        fill          <= '0;
        full          <= 1'b0;
      end else if (accept && !full) begin
        if (fill == k_last) begin
          full <= 1'b1;
          fill <= '0;
        end else begin
          fill <= fill + IW'(1);
        end
      end
      pend         <= pend_next;
      median_valid <= median_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      median <= sort_val[mid];
    end
  end

  // ---------------------------------------------------------------------
  // Cell rows. The arrival line shows the sample that leaves next in its
  // first entry; the sorted row uses it to find which entry to drop.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cells
    if (i == WINDOW_MAX - 1) begin : g_top
      assign arr_up[i]   = '0;
      assign up_flags[i] = '0;
      assign up_val[i]   = '0;
    end else begin : g_mid
      assign arr_up[i]   = arr_val[i+1];
      assign up_flags[i] = sort_flags[i+1];
      assign up_val[i]   = sort_val[i+1];
    end

    // The bottom cell sees a virtual entry below every sample, so a new
    // sample smaller than all others lands there.
    if (i == 0) begin : g_bottom
      assign low_pass[i] = '{vld: 1'b0, lt_v: 1'b1};
      assign low_val[i]  = '0;
    end else begin : g_above
      assign low_pass[i] = sort_pass[i-1];
      assign low_val[i]  = sort_pval[i-1];
    end

    swm_arr_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .IDX_W       (IW),
      .POS         (i)
    ) u_arr (
      .clk     (clk),
      .ctl     (ctl),
      .fill    (fill),
      .k_last  (k_last),
      .sample  (sample),
      .up_value(arr_up[i]),
      .value   (arr_val[i])
    );

    swm_sort_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_sort (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sample    (sample),
      .oldest    (arr_val[0]),
      .up_flags  (up_flags[i]),
      .up_value  (up_val[i]),
      .low_pass  (low_pass[i]),
      .low_value (low_val[i]),
      .flags     (sort_flags[i]),
      .value     (sort_val[i]),
      .pass      (sort_pass[i]),
      .pass_value(sort_pval[i])
    );

    assign vld_vec[i] = sort_flags[i].vld;
  end

  // Neighboring occupied entries must stay in ascending order, and the
  // occupied entries must form one block from the bottom.
  always_comb begin
    order_ok = 1'b1;
    for (int i = 0; i + 1 < WINDOW_MAX; i++) begin
      if (vld_vec[i+1] && !(vld_vec[i] && (sort_val[i] <= sort_val[i+1]))) begin
        order_ok = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `SWM_ASSERT(a_sorted_ascending, clk, rst, order_ok)
  `SWM_ASSERT(a_fill_matches_cells, clk, rst, $countones(vld_vec) == (full ? int'(k_last) + 1 : int'(fill)))
  `SWM_ASSERT_NEXT(a_cfg_empties_window, clk, rst, cfg_write, vld_vec == '0)
  `SWM_ASSERT(a_pending_needs_full, clk, rst, !pend || full)

endmodule

`default_nettype wire
